### rtl/lprc_pkg.sv
// Shared types, register indexes, reset values and the seconds-left helper
// for the long-press reset classifier. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lprc_pkg;

    localparam int HELD_W  = 16;
    localparam int DEB_W   = 10;
    localparam int POLL_W  = 10;
    localparam int SECS_W  = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POLL     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ARM      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD     = 2'd3;

    localparam logic [DEB_W-1:0]  DEBOUNCE_RST = 10'd20;
    localparam logic [POLL_W-1:0] POLL_RST     = 10'd100;
    localparam logic [HELD_W-1:0] ARM_RST      = 16'd2000;
    localparam logic [HELD_W-1:0] HOLD_RST     = 16'd10000;

    // Reciprocal of 1000 scaled by 2^27, exact for dividends below 2^17
    localparam int RECIP_SHIFT = 27;
    localparam logic [17:0] RECIP_1000 = 18'd134218;
    localparam logic [16:0] ROUND_UP   = 17'd999;

    typedef enum logic [1:0] {
        PHASE_IDLE    = 2'd0,
        PHASE_HOLDING = 2'd1,
        PHASE_SPENT   = 2'd2
    } phase_t;

    typedef struct packed {
        logic [DEB_W-1:0]  debounce_ms;
        logic [POLL_W-1:0] poll_period_ms;
        logic [HELD_W-1:0] arm_ms;
        logic [HELD_W-1:0] reset_hold_ms;
    } cfg_t;

    typedef struct packed {
        phase_t            phase;
        logic [HELD_W-1:0] held_time;
        logic              countdown_seen;
    } state_t;

    typedef struct packed {
        logic              countdown_valid;
        logic [SECS_W-1:0] countdown_seconds;
        logic              wake_request;
        logic              abort_prompt;
        logic              reset_request;
    } result_t;

    // ceil((hold - held) / 1000), zero once held has reached hold
    function automatic logic [SECS_W-1:0] seconds_left(
        input logic [HELD_W-1:0] held,
        input logic [HELD_W-1:0] hold
    );
        logic [16:0] diff;
        logic [34:0] prod;
        logic [SECS_W-1:0] secs;
        diff = {1'b0, hold} - {1'b0, held} + ROUND_UP;
        prod = {18'd0, diff} * {17'd0, RECIP_1000};
        secs = prod[RECIP_SHIFT +: SECS_W];
        if (held >= hold)
        begin
            secs = '0;
        end
        return secs;
    endfunction

endpackage

`default_nettype wire

### rtl/lprc_cfg.sv
// Configuration register bank for the long-press reset classifier.
// Depends on lprc_pkg for the register indexes, reset values and cfg_t.
`timescale 1ns / 1ps
`default_nettype none

module lprc_cfg (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [lprc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [lprc_pkg::CFG_DATA_W-1:0]  cfg_data,
    output lprc_pkg::cfg_t                        cfg
);

    lprc_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ms    <= lprc_pkg::DEBOUNCE_RST;
            cfg_reg.poll_period_ms <= lprc_pkg::POLL_RST;
            cfg_reg.arm_ms         <= lprc_pkg::ARM_RST;
            cfg_reg.reset_hold_ms  <= lprc_pkg::HOLD_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                lprc_pkg::REG_DEBOUNCE:
                    cfg_reg.debounce_ms <= cfg_data[lprc_pkg::DEB_W-1:0];
                lprc_pkg::REG_POLL:
                    cfg_reg.poll_period_ms <= cfg_data[lprc_pkg::POLL_W-1:0];
                lprc_pkg::REG_ARM:
                    cfg_reg.arm_ms <= cfg_data;
                lprc_pkg::REG_HOLD:
                    cfg_reg.reset_hold_ms <= cfg_data;
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

### rtl/lprc_step.sv
// Per-sample decision logic: next hold state and result word from one sample.
// Depends on lprc_pkg for phase_t, cfg_t, state_t, result_t and seconds_left.
`timescale 1ns / 1ps
`default_nettype none

module lprc_step (
    input  wire logic            pressed,
    input  lprc_pkg::state_t     state,
    input  lprc_pkg::cfg_t       cfg,
    output lprc_pkg::state_t     state_next,
    output lprc_pkg::result_t    result
);

    logic [lprc_pkg::HELD_W:0] sum;

    always_comb
    begin
        sum = {1'b0, state.held_time}
            + {{(lprc_pkg::HELD_W + 1 - lprc_pkg::POLL_W){1'b0}}, cfg.poll_period_ms};
        state_next = state;
        result     = '0;

        unique case (state.phase)
            lprc_pkg::PHASE_IDLE:
            begin
                if (pressed)
                begin
                    state_next.phase     = lprc_pkg::PHASE_HOLDING;
                    state_next.held_time = {{(lprc_pkg::HELD_W - lprc_pkg::DEB_W){1'b0}},
                                            cfg.debounce_ms};
                    state_next.countdown_seen = 1'b0;
                end
            end
            lprc_pkg::PHASE_HOLDING:
            begin
                if (pressed)
                begin
                    // saturate the elapsed time
                    state_next.held_time = sum[lprc_pkg::HELD_W] ? '1
                                                                 : sum[lprc_pkg::HELD_W-1:0];
                end
                else
                begin
                    result.abort_prompt = state.countdown_seen;
                    result.wake_request = !state.countdown_seen;
                    state_next.phase          = lprc_pkg::PHASE_IDLE;
                    state_next.held_time      = '0;
                    state_next.countdown_seen = 1'b0;
                end
            end
            default:
            begin
                // spent: hold until reset
                state_next = state;
            end
        endcase

        if (state_next.phase == lprc_pkg::PHASE_HOLDING && pressed)
        begin
            if (state_next.held_time >= cfg.arm_ms)
            begin
                result.countdown_valid   = 1'b1;
                result.countdown_seconds = lprc_pkg::seconds_left(state_next.held_time,
                                                                  cfg.reset_hold_ms);
                state_next.countdown_seen = 1'b1;
            end
            if (state_next.held_time >= cfg.reset_hold_ms)
            begin
                result.reset_request = 1'b1;
                state_next.phase     = lprc_pkg::PHASE_SPENT;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/long_press_reset_classifier.sv
// Top level of the long-press reset classifier: sample register, hold state,
// result register. Depends on lprc_pkg, lprc_cfg and lprc_step.
//
// Usage: each word on the input channel (in_valid/in_ready, button_pressed)
// is one poll-tick sample of the button. Every sample yields exactly one
// result word on the output channel (out_valid/out_ready) carrying
// countdown_valid, countdown_seconds, wake_request, abort_prompt and
// reset_request. Configuration words (cfg_valid/cfg_ready, cfg_index,
// cfg_data) are taken in any cycle; write them only while no sample is in
// flight.
// A sample accepted into the sample register is presented as a result once it
// moves on into the result register. Throughput: one sample per cycle while
// out_ready is high; the per-sample add, compares and multiply by the reciprocal
// of 1000 fit between the sample register and the result register.
// Stall: when out_ready is low the result holds, the sample register holds
// behind it, and in_ready drops only once both are full.
// Reset: the registers return to debounce 20, poll 100, arm 2000 and hold
// 10000 ms, the block returns to idle and both stages empty. A block that
// has raised reset_request stays spent until the next reset.
`timescale 1ns / 1ps
`default_nettype none

module long_press_reset_classifier (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic                             button_pressed,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic                                  countdown_valid,
    output logic [lprc_pkg::SECS_W-1:0]           countdown_seconds,
    output logic                                  wake_request,
    output logic                                  abort_prompt,
    output logic                                  reset_request,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [lprc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [lprc_pkg::CFG_DATA_W-1:0]  cfg_data
);

    lprc_pkg::cfg_t    cfg;
    lprc_pkg::state_t  state_reg;
    lprc_pkg::state_t  state_next;
    lprc_pkg::result_t result_next;
    lprc_pkg::result_t result_reg;
    logic              sample_valid_reg;
    logic              sample_reg;
    logic              out_valid_reg;
    logic              advance;

    // move the sample on whenever the result register is free or draining
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !sample_valid_reg || advance;

    lprc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lprc_step u_step (
        .pressed    (sample_reg),
        .state      (state_reg),
        .cfg        (cfg),
        .state_next (state_next),
        .result     (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_valid_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
            state_reg.phase          <= lprc_pkg::PHASE_IDLE;
            state_reg.held_time      <= '0;
            state_reg.countdown_seen <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                sample_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= sample_valid_reg;
                if (sample_valid_reg)
                begin
                    state_reg <= state_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            sample_reg <= button_pressed;
        end
        if (advance && sample_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign countdown_valid   = result_reg.countdown_valid;
    assign countdown_seconds = result_reg.countdown_seconds;
    assign wake_request      = result_reg.wake_request;
    assign abort_prompt      = result_reg.abort_prompt;
    assign reset_request     = result_reg.reset_request;

endmodule

`default_nettype wire
